// ===== design/cckb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Blitter package
// Field widths, default screen geometry and the frame-buffer write type that
// the channel interfaces and the blitter share.
// ----------------------------------------------------------------------------
package cckb_pkg;

   // Widths of the transaction fields.
   localparam int COORD_W = 11;
   localparam int SIZE_W  = 10;
   localparam int PIXEL_W = 16;
   localparam int ADDR_W  = 19;

   // Default screen geometry.
   localparam int SCREEN_W_DEF    = 480;
   localparam int SCREEN_H_DEF    = 272;
   localparam int LINE_PITCH_DEF  = 512;
   localparam int FRAME_WORDS_DEF = 139264;

   // Command codes of the request channel.
   typedef enum logic {
      CMD_START = 1'b0,
      CMD_PIXEL = 1'b1
   } cmd_type;

   // One frame-buffer write.
   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] data;
   } fb_write_type;

endpackage
`default_nettype wire

// ===== design/cckb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Blitter channel interfaces
// Valid/ready channels for requests, frame-buffer writes and the key register.
// ----------------------------------------------------------------------------

// Request channel: start commands and source pixels.
interface cckb_req_if
   import cckb_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic signed [COORD_W-1:0] origin_x;
   logic signed [COORD_W-1:0] origin_y;
   logic [SIZE_W-1:0]         rect_width;
   logic [SIZE_W-1:0]         rect_height;
   logic                      surface;
   logic                      use_key;
   logic [PIXEL_W-1:0]        pixel;

   modport source (output valid, command, origin_x, origin_y, rect_width,
                   rect_height, surface, use_key, pixel, input ready);
   modport sink   (input valid, command, origin_x, origin_y, rect_width,
                   rect_height, surface, use_key, pixel, output ready);
endinterface

// Result channel: frame-buffer writes.
interface cckb_rsp_if
   import cckb_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  write_address;
   logic [PIXEL_W-1:0] write_data;

   modport source (output valid, write_address, write_data, input ready);
   modport sink   (input valid, write_address, write_data, output ready);
endinterface

// Key color register write channel.
interface cckb_csr_if
   import cckb_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/clipped_color_key_blitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped color-key blitter
// Places a streamed rectangle of 16-bit pixels on one of two frame buffers,
// dropping off-screen pixels and, with keying on, key-colored pixels.
//
//   Channel  Direction  Transaction
//   req_ch   in         start command (geometry) or one source pixel
//   rsp_ch   out        one frame-buffer write (address, data)
//   csr_ch   in         write of the key color register
//
// One request per clock is sustained while rsp_ch takes writes. A write is
// registered in the output register, or in the skid register when the
// output register holds one that rsp_ch has not taken. This two-entry stage
// decouples the sides: req_ch stalls only when both entries hold writes.
// Synchronous reset clears the blit state, the key color and the output.
// ----------------------------------------------------------------------------
module clipped_color_key_blitter
   import cckb_pkg::*;
#(
   parameter int SCREEN_W    = SCREEN_W_DEF,
   parameter int SCREEN_H    = SCREEN_H_DEF,
   parameter int LINE_PITCH  = LINE_PITCH_DEF,
   parameter int FRAME_WORDS = FRAME_WORDS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   cckb_req_if.sink   req_ch,
   cckb_rsp_if.source rsp_ch,
   cckb_csr_if.sink   csr_ch
);

   localparam int SUM_W = COORD_W + 1;
   localparam logic signed [SUM_W-1:0] SCREEN_W_S = SUM_W'(SCREEN_W);
   localparam logic signed [SUM_W-1:0] SCREEN_H_S = SUM_W'(SCREEN_H);
   localparam logic [ADDR_W-1:0] PITCH_A = ADDR_W'(LINE_PITCH);
   localparam logic [ADDR_W-1:0] FRAME_A = ADDR_W'(FRAME_WORDS);

   // Blit state.
   logic signed [COORD_W-1:0] org_x_ff, org_x_in;
   logic signed [COORD_W-1:0] org_y_ff, org_y_in;
   logic [SIZE_W-1:0]         width_ff, width_in;
   logic [SIZE_W-1:0]         height_ff, height_in;
   logic                      surface_ff, surface_in;
   logic                      keyed_ff, keyed_in;
   logic [SIZE_W-1:0]         column_ff, column_in;
   logic [SIZE_W-1:0]         row_ff, row_in;
   logic                      busy_ff, busy_in;
   logic [PIXEL_W-1:0]        key_ff, key_in;

   // Output stage.
   logic         main_valid_ff, main_valid_in;
   fb_write_type main_ff, main_in;
   logic         skid_valid_ff, skid_valid_in;
   fb_write_type skid_ff, skid_in;

   logic                    accept;
   logic                    pop;
   logic                    push;
   logic signed [SUM_W-1:0] x_pos;
   logic signed [SUM_W-1:0] y_pos;
   logic                    on_screen;
   logic                    opaque;
   logic [SIZE_W:0]         column_next;
   logic [SIZE_W:0]         row_next;
   fb_write_type            wr;

   assign req_ch.ready = !skid_valid_ff;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = main_valid_ff && rsp_ch.ready;

   // Destination position and the clip and key tests.
   assign x_pos     = SUM_W'(org_x_ff) + $signed({2'b00, column_ff});
   assign y_pos     = SUM_W'(org_y_ff) + $signed({2'b00, row_ff});
   assign on_screen = (x_pos >= 0) && (x_pos < SCREEN_W_S)
                   && (y_pos >= 0) && (y_pos < SCREEN_H_S);
   assign opaque    = !keyed_ff || (req_ch.pixel != key_ff);
   assign push      = accept && (req_ch.command == CMD_PIXEL) && busy_ff
                   && on_screen && opaque;

   // Word address, wrapped to the address width.
   assign wr.addr = (surface_ff ? FRAME_A : '0)
                  + ADDR_W'({{(ADDR_W-SIZE_W){1'b0}}, y_pos[SIZE_W-1:0]} * PITCH_A)
                  + {{(ADDR_W-SIZE_W){1'b0}}, x_pos[SIZE_W-1:0]};
   assign wr.data = req_ch.pixel;

   assign column_next = {1'b0, column_ff} + 1'b1;
   assign row_next    = {1'b0, row_ff} + 1'b1;

   // Next blit state: a start reloads the geometry, a pixel steps the raster.
   always_comb begin
      org_x_in   = org_x_ff;
      org_y_in   = org_y_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      surface_in = surface_ff;
      keyed_in   = keyed_ff;
      column_in  = column_ff;
      row_in     = row_ff;
      busy_in    = busy_ff;
      key_in     = csr_ch.valid ? csr_ch.data : key_ff;
      if (accept) begin
         case (req_ch.command)
            CMD_START: begin
               org_x_in   = req_ch.origin_x;
               org_y_in   = req_ch.origin_y;
               width_in   = req_ch.rect_width;
               height_in  = req_ch.rect_height;
               surface_in = req_ch.surface;
               keyed_in   = req_ch.use_key;
               column_in  = '0;
               row_in     = '0;
               busy_in    = (req_ch.rect_width != '0) && (req_ch.rect_height != '0);
            end
            CMD_PIXEL: begin
               if (busy_ff) begin
                  if (column_next >= {1'b0, width_ff}) begin
                     column_in = '0;
                     if (row_next >= {1'b0, height_ff}) begin
                        row_in  = '0;
                        busy_in = 1'b0;
                     end else begin
                        row_in = row_next[SIZE_W-1:0];
                     end
                  end else begin
                     column_in = column_next[SIZE_W-1:0];
                  end
               end
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end
   end

   // Output register with skid entry behind it.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push && main_valid_ff && !pop) begin
         skid_in       = wr;
         skid_valid_in = 1'b1;
      end else if (push) begin
         main_in       = wr;
         main_valid_in = 1'b1;
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff      <= '0;
         org_y_ff      <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         surface_ff    <= 1'b0;
         keyed_ff      <= 1'b0;
         column_ff     <= '0;
         row_ff        <= '0;
         busy_ff       <= 1'b0;
         key_ff        <= '0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         org_x_ff      <= org_x_in;
         org_y_ff      <= org_y_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         surface_ff    <= surface_in;
         keyed_ff      <= keyed_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         busy_ff       <= busy_in;
         key_ff        <= key_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Write payload registers.
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid         = main_valid_ff;
   assign rsp_ch.write_address = main_ff.addr;
   assign rsp_ch.write_data    = main_ff.data;

endmodule
`default_nettype wire

// ===== dv/cckb_write_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blitter write checker
// Watches the request, write and key register channels of the blitter. It
// keeps its own copy of the blit state, predicts the frame-buffer write
// that each accepted pixel causes, and compares every accepted write with
// the oldest prediction.
// ----------------------------------------------------------------------------
module cckb_write_checker
   import cckb_pkg::*;
#(
   parameter int SCREEN_W    = SCREEN_W_DEF,
   parameter int SCREEN_H    = SCREEN_H_DEF,
   parameter int LINE_PITCH  = LINE_PITCH_DEF,
   parameter int FRAME_WORDS = FRAME_WORDS_DEF
) (
   input  wire clock,
   input  wire reset,
   cckb_req_if req_mon,
   cckb_rsp_if rsp_mon,
   cckb_csr_if csr_mon,
   output int  mismatch_count,
   output int  writes_pending,
   output int  writes_checked,
   output int  starts_seen,
   output int  pixels_clipped,
   output int  pixels_keyed_out,
   output int  pixels_dropped
);

   // Shadow copy of the blit state and the key color register.
   logic [PIXEL_W-1:0]        key_color;
   logic signed [COORD_W-1:0] dest_x;
   logic signed [COORD_W-1:0] dest_y;
   logic [SIZE_W-1:0]         span_w;
   logic [SIZE_W-1:0]         span_h;
   logic                      target_surface;
   logic                      keying_on;
   logic [SIZE_W-1:0]         col_pos;
   logic [SIZE_W-1:0]         row_pos;
   logic                      blit_active;

   // Writes predicted but not yet seen on the write channel.
   fb_write_type expected_writes[$];

   // Update the shadow state for one request and queue the write it causes.
   task automatic predict_fb_write();
      int             px;
      int             py;
      longint         full_addr;
      logic           on_screen;
      logic           opaque;
      fb_write_type   wr;
      if (req_mon.command == CMD_START) begin
         starts_seen++;
         dest_x         = req_mon.origin_x;
         dest_y         = req_mon.origin_y;
         span_w         = req_mon.rect_width;
         span_h         = req_mon.rect_height;
         target_surface = req_mon.surface;
         keying_on      = req_mon.use_key;
         col_pos        = '0;
         row_pos        = '0;
         blit_active    = (req_mon.rect_width != 0) && (req_mon.rect_height != 0);
      end else if (!blit_active) begin
         pixels_dropped++;
      end else begin
         px = int'(dest_x) + int'(col_pos);
         py = int'(dest_y) + int'(row_pos);
         on_screen = (px >= 0) && (px < SCREEN_W) && (py >= 0) && (py < SCREEN_H);
         opaque    = !keying_on || (req_mon.pixel != key_color);
         if (!on_screen) begin
            pixels_clipped++;
         end else if (!opaque) begin
            pixels_keyed_out++;
         end else begin
            full_addr = longint'(target_surface) * FRAME_WORDS
                      + longint'(py) * LINE_PITCH + longint'(px);
            wr.addr = ADDR_W'(full_addr);
            wr.data = req_mon.pixel;
            expected_writes.push_back(wr);
         end

         // Step through the rectangle in raster order.
         if (int'(col_pos) + 1 >= int'(span_w)) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= int'(span_h)) begin
               row_pos     = '0;
               blit_active = 1'b0;
            end else begin
               row_pos = row_pos + 1'b1;
            end
         end else begin
            col_pos = col_pos + 1'b1;
         end
      end
   endtask

   // Check writes first: a write never comes from a request of the same edge.
   always @(posedge clock) begin : monitor
      fb_write_type want;
      if (reset) begin
         key_color        = '0;
         dest_x           = '0;
         dest_y           = '0;
         span_w           = '0;
         span_h           = '0;
         target_surface   = 1'b0;
         keying_on        = 1'b0;
         col_pos          = '0;
         row_pos          = '0;
         blit_active      = 1'b0;
         expected_writes.delete();
         mismatch_count   = 0;
         writes_checked   = 0;
         starts_seen      = 0;
         pixels_clipped   = 0;
         pixels_keyed_out = 0;
         pixels_dropped   = 0;
         writes_pending  <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_writes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t: unexpected write addr=%h data=%h", $realtime,
                           rsp_mon.write_address, rsp_mon.write_data);
            end else begin
               want = expected_writes.pop_front();
               writes_checked++;
               if (rsp_mon.write_address !== want.addr ||
                   rsp_mon.write_data !== want.data) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%t: write mismatch: expected addr=%h data=%h, got addr=%h data=%h",
                              $realtime, want.addr, want.data,
                              rsp_mon.write_address, rsp_mon.write_data);
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready)
            key_color = csr_mon.data;
         if (req_mon.valid && req_mon.ready)
            predict_fb_write();
         writes_pending <= expected_writes.size();
      end
   end

endmodule

// ===== dv/clipped_color_key_blitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blitter testbench
// Drives start commands and pixel streams into the blitter through a few key
// color settings, with random idling on both sides, a long output stall and
// pauses for the writes to drain. A checker beside the block predicts and
// compares every frame-buffer write; this module gives the verdict.
// ----------------------------------------------------------------------------
module clipped_color_key_blitter_tb;
   import cckb_pkg::*;

   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 4;

   typedef struct {
      cmd_type                   command;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [SIZE_W-1:0]         rect_width;
      logic [SIZE_W-1:0]         rect_height;
      logic                      surface;
      logic                      use_key;
      logic [PIXEL_W-1:0]        pixel;
   } req_item_type;

   logic clock = 1'b0;
   logic reset;

   cckb_req_if req_if();
   cckb_rsp_if rsp_if();
   cckb_csr_if csr_if();

   int mismatches;
   int writes_pending;
   int writes_checked;
   int starts_seen;
   int pixels_clipped;
   int pixels_keyed_out;
   int pixels_dropped;

   int             items_sent = 0;
   int             stall_requests = 0;
   int             stalls_served = 0;
   int             key_settings = 1;
   logic           no_idle = 1'b0;
   logic           req_quiet = 1'b0;
   logic [PIXEL_W-1:0] key_now = '0;

   clipped_color_key_blitter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   cckb_write_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_mon          (csr_if),
      .mismatch_count   (mismatches),
      .writes_pending   (writes_pending),
      .writes_checked   (writes_checked),
      .starts_seen      (starts_seen),
      .pixels_clipped   (pixels_clipped),
      .pixels_keyed_out (pixels_keyed_out),
      .pixels_dropped   (pixels_dropped)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Item with every field random; commands overwrite the fields they use.
   function automatic req_item_type junk_item();
      req_item_type it;
      it.command     = cmd_type'(1'($urandom));
      it.origin_x    = COORD_W'($urandom);
      it.origin_y    = COORD_W'($urandom);
      it.rect_width  = SIZE_W'($urandom);
      it.rect_height = SIZE_W'($urandom);
      it.surface     = 1'($urandom);
      it.use_key     = 1'($urandom);
      it.pixel       = PIXEL_W'($urandom);
      return it;
   endfunction

   // Pixel value that hits the key color now and then on keyed blits.
   function automatic logic [PIXEL_W-1:0] random_pixel(input logic keyed);
      if (keyed && $urandom_range(0, 3) == 0)
         return key_now;
      return PIXEL_W'($urandom);
   endfunction

   // Offer one transaction and hold it until accepted, then maybe idle.
   task automatic send_req(input req_item_type it);
      req_if.valid       <= 1'b1;
      req_if.command     <= it.command;
      req_if.origin_x    <= it.origin_x;
      req_if.origin_y    <= it.origin_y;
      req_if.rect_width  <= it.rect_width;
      req_if.rect_height <= it.rect_height;
      req_if.surface     <= it.surface;
      req_if.use_key     <= it.use_key;
      req_if.pixel       <= it.pixel;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      items_sent++;
      if (!no_idle && !req_quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_start(input int ox, input int oy, input int w, input int h,
                             input logic surf, input logic keyed);
      req_item_type it;
      it             = junk_item();
      it.command     = CMD_START;
      it.origin_x    = COORD_W'(ox);
      it.origin_y    = COORD_W'(oy);
      it.rect_width  = SIZE_W'(w);
      it.rect_height = SIZE_W'(h);
      it.surface     = surf;
      it.use_key     = keyed;
      send_req(it);
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      req_item_type it;
      it         = junk_item();
      it.command = CMD_PIXEL;
      it.pixel   = pix;
      send_req(it);
   endtask

   // Stop offering requests until every predicted write has come out.
   task automatic wait_writes_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (writes_pending != 0)
         @(posedge clock);
   endtask

   // Key color writes happen only with the block idle.
   task automatic write_key(input logic [PIXEL_W-1:0] value);
      wait_writes_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      csr_if.valid <= 1'b0;
      key_now = value;
      key_settings++;
   endtask

   // One random blit: mostly well formed, some broken, empty or stray.
   // The long line is kept within the requests left in the phase.
   task automatic run_blit_sequence(input int room);
      int   kind;
      int   ox;
      int   oy;
      int   w;
      int   h;
      int   n;
      logic keyed;
      kind      = $urandom_range(0, 99);
      req_quiet = ($urandom_range(0, 3) == 0);
      keyed     = 1'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         ox = $urandom_range(0, 2047) - 1024;
         oy = $urandom_range(0, 2047) - 1024;
      end else begin
         ox = $urandom_range(0, 511) - 16;
         oy = $urandom_range(0, 303) - 16;
      end
      if (kind < 12) begin
         // Stray pixels, with or without a blit in progress.
         repeat ($urandom_range(1, 4)) send_pixel(random_pixel(keyed));
      end else if (kind < 20) begin
         // Empty rectangle: the pixels after it are dropped.
         if ($urandom_range(0, 1) == 0) begin
            w = 0;
            h = $urandom_range(0, 1023);
         end else begin
            w = $urandom_range(0, 1023);
            h = 0;
         end
         send_start(ox, oy, w, h, 1'($urandom), keyed);
         repeat ($urandom_range(1, 2)) send_pixel(random_pixel(keyed));
      end else if (kind < 22) begin
         // A long single line, which may run off the right edge.
         w = $urandom_range(300, 1023);
         if (w >= room)
            w = (room > 1) ? room - 1 : 1;
         send_start(ox, oy, w, 1, 1'($urandom), keyed);
         repeat (w) send_pixel(random_pixel(keyed));
      end else begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 8);
         n = w * h;
         if (kind < 34)
            n = $urandom_range(0, w * h - 1);
         else if (kind < 44)
            n = n + $urandom_range(1, 3);
         send_start(ox, oy, w, h, 1'($urandom), keyed);
         repeat (n) send_pixel(random_pixel(keyed));
      end
   endtask

   task automatic random_phase(input int item_target);
      while (items_sent < item_target)
         run_blit_sequence(item_target - items_sent);
      req_quiet = 1'b0;
   endtask

   // Write side: random stalls, quiet stretches and the long hold-off.
   initial begin : write_sink
      int mode_left;
      logic sink_quiet;
      mode_left     = 0;
      sink_quiet    = 1'b0;
      rsp_if.ready  = 1'b0;
      forever begin
         if (mode_left == 0) begin
            sink_quiet = ($urandom_range(0, 2) == 0);
            mode_left  = 150;
         end
         mode_left--;
         if (stall_requests != stalls_served) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            stalls_served++;
         end else if (!no_idle && !sink_quiet && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Ends the run when no transaction moves on any channel for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Stimulus.
   initial begin : stimulus
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.command     = CMD_START;
      req_if.origin_x    = '0;
      req_if.origin_y    = '0;
      req_if.rect_width  = '0;
      req_if.rect_height = '0;
      req_if.surface     = 1'b0;
      req_if.use_key     = 1'b0;
      req_if.pixel       = '0;
      csr_if.valid       = 1'b0;
      csr_if.data        = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, key color at its reset value of zero.
      // A pixel before any start is dropped.
      send_pixel(16'hA5A5);
      // Largest geometry, entirely off screen, then restarted mid-blit.
      send_start(1023, 1023, 1023, 1023, 1'b1, 1'b1);
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      send_start(-1024, -1024, 1023, 1023, 1'b0, 1'b0);
      // Zero width and zero height leave the block idle.
      send_start(10, 10, 0, 5, 1'b0, 1'b0);
      send_pixel(16'h0001);
      send_start(10, 10, 5, 0, 1'b1, 1'b0);
      send_pixel(16'h0002);
      // Clipped at the top-left corner with keying on.
      send_start(-1, -1, 3, 2, 1'b1, 1'b1);
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      send_pixel(16'h0001);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      send_pixel(16'h8000);
      // Clipped by the right edge at the bottom-right corner, then a pixel past the end.
      send_start(478, 270, 3, 2, 1'b0, 1'b0);
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      send_pixel(16'h5555);
      send_pixel(16'hAAAA);
      send_pixel(16'h0000);
      send_pixel(16'h7FFF);
      send_pixel(16'h1234);
      // Last on-screen pixel of the second surface, opaque zero.
      send_start(479, 271, 1, 1, 1'b1, 1'b0);
      send_pixel(16'h0000);

      // Random phases over several key colors.
      random_phase(300);
      write_key(16'hFFFF);
      random_phase(580);

      // Long write stall while the requests keep coming.
      write_key(PIXEL_W'($urandom));
      req_quiet = 1'b1;
      stall_requests++;
      send_start(100, 100, 8, 5, 1'b0, 1'b0);
      repeat (40) send_pixel(PIXEL_W'($urandom));
      random_phase(860);

      write_key(16'h0000);
      random_phase(1140);

      // Final phase with no idling on either side.
      write_key(PIXEL_W'($urandom));
      no_idle = 1'b1;
      random_phase(1420);

      wait_writes_drained();
      repeat (20) @(posedge clock);

      $display("Sent %0d requests (%0d starts) over %0d key colors; %0d writes checked.",
               items_sent, starts_seen, key_settings, writes_checked);
      $display("Pixels clipped %0d, skipped by key %0d, dropped while idle %0d.",
               pixels_clipped, pixels_keyed_out, pixels_dropped);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
design/cckb_pkg.sv
design/cckb_if.sv
design/clipped_color_key_blitter.sv
dv/cckb_write_checker.sv
dv/clipped_color_key_blitter_tb.sv
